// ===== rtl/core/csps_pkg.sv =====
// shared widths, register codes and helpers for the cumulative scan unit
package csps_pkg;

  // storage depths
  localparam int unsigned MAX_LANES  = 1024;
  localparam int unsigned SLAB_DEPTH = 4096;

  // field and counter widths
  localparam int unsigned LANE_W    = $clog2(MAX_LANES);
  localparam int unsigned SLAB_AW   = $clog2(SLAB_DEPTH);
  localparam int unsigned AXIS_W    = 12;
  localparam int unsigned POS_W     = 12;
  localparam int unsigned LEN_W     = 13;
  localparam int unsigned CNT_W     = 11;
  localparam int unsigned DATA_W    = 64;
  localparam int unsigned HALF_W    = DATA_W / 2;
  localparam int unsigned CFG_W     = 13;
  localparam int unsigned CFG_IDX_W = 3;

  // clamp limits for the length registers
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(4096);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(1024);

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COMBINE   = 3'd0,
    REG_EXCLUSIVE = 3'd1,
    REG_REVERSE   = 3'd2,
    REG_WIDE      = 3'd3,
    REG_AXIS_LEN  = 3'd4,
    REG_INNER_CNT = 3'd5
  } cfg_reg_t;

  // item opcodes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // wrap to signed 32 bits when narrow
  function automatic logic [DATA_W-1:0] fit_width(input logic [DATA_W-1:0] v,
                                                   input logic wide);
    logic [DATA_W-1:0] r;
    if (wide) begin
      r = v;
    end else begin
      r = {{HALF_W{v[HALF_W-1]}}, v[HALF_W-1:0]};
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/csps_channel_if.sv =====
// valid/ready channel interfaces for scan items and scan results
interface csps_in_if;
  logic                                valid;
  logic                                ready;
  logic                                opcode;
  logic signed [csps_pkg::DATA_W-1:0]  element_value;

  modport source (output valid, output opcode, output element_value, input ready);
  modport sink   (input valid, input opcode, input element_value, output ready);
endinterface

interface csps_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [csps_pkg::DATA_W-1:0]  scan_value;
  logic        [csps_pkg::POS_W-1:0]   slab_position;
  logic                                slab_end;

  modport source (output valid, output scan_value, output slab_position, output slab_end,
                  input ready);
  modport sink   (input valid, input scan_value, input slab_position, input slab_end,
                  output ready);
endinterface

// ===== rtl/core/cumulative_sum_product_scan_unit.sv =====
// cumulative sum/product scan: lane accumulator memory, slab buffer memory, 2-stage pipe
// a scanning item passes stage 1, stage 2 and the output register before its result is presented
// throughput: one item per clock while the result channel is not stalled; product mode
//   with one or two lanes waits on the accumulator write back of the same lane
// reset: rst (synchronous) clears counters, pipe valids and restores register defaults;
//   the accumulator and slab memories are not cleared
module cumulative_sum_product_scan_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [csps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [csps_pkg::CFG_W-1:0]       cfg_data,
  csps_in_if.sink                          scan_in,
  csps_out_if.source                       scan_out
);

  localparam int unsigned LW = csps_pkg::LANE_W;
  localparam int unsigned DW = csps_pkg::DATA_W;
  localparam int unsigned HW = csps_pkg::HALF_W;
  localparam int unsigned AW = csps_pkg::AXIS_W;
  localparam int unsigned PW = csps_pkg::POS_W;
  localparam int unsigned NW = csps_pkg::LEN_W;
  localparam int unsigned CW = csps_pkg::CNT_W;
  localparam int unsigned SW = csps_pkg::SLAB_AW;

  // configuration registers
  logic          combine_mode;
  logic          exclusive_mode;
  logic          reverse_order;
  logic          wide_elements;
  logic [NW-1:0] axis_length;
  logic [CW-1:0] inner_count;

  // sequencing state
  logic [AW-1:0] axis_counter;
  logic [LW-1:0] lane_counter;
  logic [PW-1:0] pos;
  logic          drain_pending;

  // memories
  logic [DW-1:0] acc_mem  [csps_pkg::MAX_LANES];
  logic [DW-1:0] slab_mem [csps_pkg::SLAB_DEPTH];
  logic [DW-1:0] acc_rd;
  logic [DW-1:0] slab_rd;

  // stage 1 registers
  logic          s1_v;
  logic [LW-1:0] s1_lane;
  logic          s1_first;
  logic          s1_drain;
  logic [DW-1:0] s1_elem;
  logic [PW-1:0] s1_pos;
  logic          s1_last;
  logic          s1_patch_v;
  logic [DW-1:0] s1_patch;

  // stage 2 registers
  logic          s2_v;
  logic [LW-1:0] s2_lane;
  logic [PW-1:0] s2_pos;
  logic          s2_last;
  logic [DW-1:0] s2_acc;
  logic [DW-1:0] s2_sum;
  logic [DW-1:0] s2_pp0;
  logic [HW-1:0] s2_pp1;
  logic [HW-1:0] s2_pp2;

  // output register
  logic          out_v;
  logic [DW-1:0] out_value;
  logic [PW-1:0] out_pos;
  logic          out_end;

  // effective lengths
  logic [NW-1:0] len_eff;
  logic [CW-1:0] lanes_eff;

  always_comb begin
    if (axis_length == '0) begin
      len_eff = NW'(1);
    end else if (axis_length > csps_pkg::MAX_LEN) begin
      len_eff = csps_pkg::MAX_LEN;
    end else begin
      len_eff = axis_length;
    end
    if (inner_count == '0) begin
      lanes_eff = CW'(1);
    end else if (inner_count > csps_pkg::MAX_CNT) begin
      lanes_eff = csps_pkg::MAX_CNT;
    end else begin
      lanes_eff = inner_count;
    end
  end

  // position decode
  logic axis_end;
  logic lane_end;
  logic load_last;
  logic drain_last;

  assign axis_end   = (NW'(axis_counter) + NW'(1)) >= len_eff;
  assign lane_end   = (CW'(lane_counter) + CW'(1)) >= lanes_eff;
  assign load_last  = axis_end && lane_end;
  assign drain_last = (axis_counter == '0) && (lane_counter == '0);

  // pipe movement
  logic out_go;
  logic s2_go;
  logic s1_go;
  logic hazard;
  logic accept;
  logic is_load;
  logic scans;
  logic load_step;
  logic drain_step;
  logic slab_wr;
  logic wr_en;
  logic [DW-1:0] s2_next;

  assign out_go = !out_v || scan_out.ready;
  assign s2_go  = !s2_v || out_go;
  assign s1_go  = !s1_v || s2_go;

  // product operands of the same lane still in flight hold the next scanning transfer
  assign hazard = combine_mode
                  && (reverse_order ? drain_pending : !drain_pending)
                  && ((s1_v && (s1_lane == lane_counter))
                      || (s2_v && (s2_lane == lane_counter)));

  assign scan_in.ready = s1_go && !hazard;
  assign accept        = scan_in.valid && scan_in.ready;
  assign is_load       = scan_in.opcode == csps_pkg::OP_LOAD;
  assign load_step     = accept && is_load && !drain_pending;
  assign drain_step    = accept && !is_load && drain_pending;
  assign scans         = (load_step && !reverse_order) || drain_step;
  assign slab_wr       = load_step && reverse_order;
  assign wr_en         = s2_v && out_go;

  // known register index
  logic cfg_known;

  always_comb begin
    case (cfg_index)
      csps_pkg::REG_COMBINE,
      csps_pkg::REG_EXCLUSIVE,
      csps_pkg::REG_REVERSE,
      csps_pkg::REG_WIDE,
      csps_pkg::REG_AXIS_LEN,
      csps_pkg::REG_INNER_CNT: cfg_known = 1'b1;
      default:                 cfg_known = 1'b0;
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      combine_mode   <= 1'b0;
      exclusive_mode <= 1'b0;
      reverse_order  <= 1'b0;
      wide_elements  <= 1'b1;
      axis_length    <= NW'(1);
      inner_count    <= CW'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        csps_pkg::REG_COMBINE:   combine_mode   <= cfg_data[0];
        csps_pkg::REG_EXCLUSIVE: exclusive_mode <= cfg_data[0];
        csps_pkg::REG_REVERSE:   reverse_order  <= cfg_data[0];
        csps_pkg::REG_WIDE:      wide_elements  <= cfg_data[0];
        csps_pkg::REG_AXIS_LEN:  axis_length    <= cfg_data[NW-1:0];
        csps_pkg::REG_INNER_CNT: inner_count    <= cfg_data[CW-1:0];
        default: ;
      endcase
    end
  end

  // axis and lane sequencing
  always_ff @(posedge clk) begin
    if (rst || (cfg_write && cfg_known)) begin
      axis_counter  <= '0;
      lane_counter  <= '0;
      pos           <= '0;
      drain_pending <= 1'b0;
    end else if (load_step) begin
      if (load_last) begin
        if (reverse_order) begin
          drain_pending <= 1'b1;
          axis_counter  <= AW'(len_eff - NW'(1));
          lane_counter  <= LW'(lanes_eff - CW'(1));
        end else begin
          axis_counter <= '0;
          lane_counter <= '0;
          pos          <= '0;
        end
      end else if (lane_end) begin
        lane_counter <= '0;
        axis_counter <= axis_counter + AW'(1);
        pos          <= pos + PW'(1);
      end else begin
        lane_counter <= lane_counter + LW'(1);
        pos          <= pos + PW'(1);
      end
    end else if (drain_step) begin
      if (drain_last) begin
        drain_pending <= 1'b0;
        axis_counter  <= '0;
        lane_counter  <= '0;
        pos           <= '0;
      end else if (lane_counter == '0) begin
        lane_counter <= LW'(lanes_eff - CW'(1));
        axis_counter <= axis_counter - AW'(1);
        pos          <= pos - PW'(1);
      end else begin
        lane_counter <= lane_counter - LW'(1);
        pos          <= pos - PW'(1);
      end
    end
  end

  // slab buffer: store on reverse loads, read for drains
  always_ff @(posedge clk) begin
    if (slab_wr) begin
      slab_mem[pos[SW-1:0]] <= scan_in.element_value;
    end
    if (scans) begin
      slab_rd <= slab_mem[pos[SW-1:0]];
    end
  end

  // lane accumulators: read on transfer, write back as stage 2 retires
  always_ff @(posedge clk) begin
    if (wr_en) begin
      acc_mem[s2_lane] <= s2_next;
    end
    if (scans) begin
      acc_rd <= acc_mem[lane_counter];
    end
  end

  // pipe valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v  <= 1'b0;
      s2_v  <= 1'b0;
      out_v <= 1'b0;
    end else begin
      if (s1_go) begin
        s1_v <= scans;
      end
      if (s2_go) begin
        s2_v <= s1_v;
      end
      if (out_go) begin
        out_v <= s2_v;
      end
    end
  end

  // stage 1 capture, with the write back retiring on the same edge
  always_ff @(posedge clk) begin
    if (s1_go && scans) begin
      s1_lane    <= lane_counter;
      s1_first   <= is_load ? (axis_counter == '0) : axis_end;
      s1_drain   <= !is_load;
      s1_elem    <= scan_in.element_value;
      s1_pos     <= pos;
      s1_last    <= is_load ? load_last : drain_last;
      s1_patch_v <= wr_en && (s2_lane == lane_counter);
      s1_patch   <= s2_next;
    end
  end

  // stage 1: operand select, sum and partial products
  logic [DW-1:0] x_fit;
  logic [DW-1:0] acc_old;
  logic [DW-1:0] sum_fit;
  logic [DW-1:0] pp0_next;
  logic [HW-1:0] pp1_next;
  logic [HW-1:0] pp2_next;

  always_comb begin
    x_fit = csps_pkg::fit_width(s1_drain ? slab_rd : s1_elem, wide_elements);
    if (s1_first) begin
      acc_old = {{(DW-1){1'b0}}, combine_mode};
    end else if (!combine_mode && s2_v && (s2_lane == s1_lane)) begin
      acc_old = s2_sum;
    end else if (s1_patch_v) begin
      acc_old = s1_patch;
    end else begin
      acc_old = acc_rd;
    end
    sum_fit = csps_pkg::fit_width(acc_old + x_fit, wide_elements);
  end

  assign pp0_next = acc_old[HW-1:0] * x_fit[HW-1:0];
  assign pp1_next = acc_old[HW-1:0] * x_fit[DW-1:HW];
  assign pp2_next = acc_old[DW-1:HW] * x_fit[HW-1:0];

  always_ff @(posedge clk) begin
    if (s1_v && s2_go) begin
      s2_lane <= s1_lane;
      s2_pos  <= s1_pos;
      s2_last <= s1_last;
      s2_acc  <= acc_old;
      s2_sum  <= sum_fit;
      s2_pp0  <= pp0_next;
      s2_pp1  <= pp1_next;
      s2_pp2  <= pp2_next;
    end
  end

  // stage 2: finish product, pick result
  logic [DW-1:0] prod;

  always_comb begin
    prod    = s2_pp0 + {s2_pp1 + s2_pp2, {HW{1'b0}}};
    s2_next = combine_mode ? csps_pkg::fit_width(prod, wide_elements) : s2_sum;
  end

  always_ff @(posedge clk) begin
    if (s2_v && out_go) begin
      out_value <= exclusive_mode ? s2_acc : s2_next;
      out_pos   <= s2_pos;
      out_end   <= s2_last;
    end
  end

  // result channel
  assign scan_out.valid         = out_v;
  assign scan_out.scan_value    = out_value;
  assign scan_out.slab_position = out_pos;
  assign scan_out.slab_end      = out_end;

endmodule
